// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every edge outside reset.
`define CHK_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Check a condition in the same cycle as its trigger.
`define CHK_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check a condition in the cycle after its trigger.
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/mtf_pkg.sv =====
package mtf_pkg;

  localparam int DEPTH      = 16;
  localparam int NAME_BYTES = 20;
  localparam int MAIL_BYTES = 32;

  localparam int NameKeep = (NAME_BYTES < 20) ? NAME_BYTES : 20;
  localparam int NAME_W   = NameKeep * 8;
  localparam int PHONE_W  = 160;
  localparam int MAIL_W   = MAIL_BYTES * 8;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int POS_W    = 4;

  typedef enum logic [1:0] {
    STAT_INSERTED  = 2'd0,
    STAT_FOUND     = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_t;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef struct packed {
    logic [NAME_W-1:0]  name;
    logic [PHONE_W-1:0] phone;
    logic [MAIL_W-1:0]  mail;
  } rec_t;

  typedef struct packed {
    logic cmp_en;     // latch the name compare
    logic shift_all;  // insert: every cell takes its neighbour's record
    logic shift_hit;  // search: cells up to the match take their neighbour's record
  } cell_ctl_t;

endpackage

// ===== hdl/mtf_req_if.sv =====
interface mtf_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [63:0] name_w0;
  logic [63:0] name_w1;
  logic [31:0] name_w2;
  logic [63:0] phone_w0;
  logic [63:0] phone_w1;
  logic [31:0] phone_w2;
  logic [63:0] mail_w0;
  logic [63:0] mail_w1;
  logic [63:0] mail_w2;
  logic [63:0] mail_w3;

  modport source (
    output valid, cmd, name_w0, name_w1, name_w2, phone_w0, phone_w1, phone_w2,
           mail_w0, mail_w1, mail_w2, mail_w3,
    input  ready
  );
  modport sink (
    input  valid, cmd, name_w0, name_w1, name_w2, phone_w0, phone_w1, phone_w2,
           mail_w0, mail_w1, mail_w2, mail_w3,
    output ready
  );
endinterface

// ===== hdl/mtf_rsp_if.sv =====
interface mtf_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  position;
  logic [63:0] found_phone_w0;
  logic [63:0] found_phone_w1;
  logic [31:0] found_phone_w2;
  logic [63:0] found_mail_w0;
  logic [63:0] found_mail_w1;
  logic [63:0] found_mail_w2;
  logic [63:0] found_mail_w3;

  modport source (
    output valid, status, position, found_phone_w0, found_phone_w1, found_phone_w2,
           found_mail_w0, found_mail_w1, found_mail_w2, found_mail_w3,
    input  ready
  );
  modport sink (
    input  valid, status, position, found_phone_w0, found_phone_w1, found_phone_w2,
           found_mail_w0, found_mail_w1, found_mail_w2, found_mail_w3,
    output ready
  );
endinterface

// ===== hdl/mtf_cell.sv =====
module mtf_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  mtf_pkg::cell_ctl_t        ctl,
  input  logic                      live,
  input  logic [mtf_pkg::NAME_W-1:0] key,
  input  mtf_pkg::rec_t             prev,
  output mtf_pkg::rec_t             rec,
  input  logic                      hit_in,
  output logic                      hit_out,
  output logic                      sel,
  output mtf_pkg::rec_t             found
);
  import mtf_pkg::*;

  logic eq;

  always_ff @(posedge clk) begin
    if (rst) begin
      eq <= 1'b0;
    end else if (ctl.cmp_en) begin
      eq <= live && (rec.name == key);
    end
  end

  // Take the neighbour's record on an insert; on a search, hold once a match lies in front of this cell.
  always_ff @(posedge clk) begin
    if (ctl.shift_all || (ctl.shift_hit && !hit_in)) begin
      rec <= prev;
    end
  end

  assign hit_out = hit_in | eq;
  assign sel     = eq & ~hit_in;
  assign found   = sel ? rec : '0;

endmodule

// ===== hdl/move_to_front_record_lookup.sv =====
// Channel  Dir  Handshake     Word
// req      in   valid/ready   cmd, name, phone, mail
// rsp      out  valid/ready   status, position, found phone and mail
//
// Each word passes through S_CMP, which latches the name compare in every
// cell, then S_UPD, which picks the first match and shifts the cell row by
// one place. A new word is taken in S_UPD of the previous one once the
// result register is free, so words overlap while rsp keeps up.
// A full result register stalls the shift cycle until rsp takes its word.
// Reset (rst, synchronous) empties the table; record contents are not cleared.
`include "assert_macros.svh"

module move_to_front_record_lookup (
  input logic       clk,
  input logic       rst,
  mtf_req_if.sink   req,
  mtf_rsp_if.source rsp
);
  import mtf_pkg::*;

  state_t state, state_next;
  logic   accept, fire, out_free, cmp_en;

  logic               cmd;
  logic [NAME_W-1:0]  key;
  logic [PHONE_W-1:0] phone;
  logic [MAIL_W-1:0]  mail;
  logic [CNT_W-1:0]   count;
  logic               full, any_hit;

  cell_ctl_t          ctl;
  rec_t               front_rec, found_rec;
  rec_t               recs  [DEPTH];
  rec_t               prevs [DEPTH];
  rec_t               founds[DEPTH];
  logic [DEPTH:0]     hits;
  logic [DEPTH-1:0]   sel;
  logic [DEPTH-1:0]   live;
  logic [POS_W-1:0]   pos;

  logic               rsp_valid;
  status_t            status;
  logic [POS_W-1:0]   position;
  logic [PHONE_W-1:0] found_phone;
  logic [255:0]       found_mail;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign out_free = !rsp_valid || rsp.ready;
  assign accept   = req.valid && req.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  state_next = accept ? S_CMP : S_IDLE;
      S_CMP:   state_next = S_UPD;
      S_UPD:   state_next = out_free ? (accept ? S_CMP : S_IDLE) : S_UPD;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    cmp_en    = 1'b0;
    fire      = 1'b0;
    unique case (state)
      S_IDLE: req.ready = 1'b1;
      S_CMP:  cmp_en    = 1'b1;
      S_UPD: begin
        req.ready = out_free;
        fire      = out_free;
      end
      default: ;
    endcase
  end

  // Item register
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd   <= req.cmd;
      key   <= NAME_W'({req.name_w2, req.name_w1, req.name_w0});
      phone <= {req.phone_w2, req.phone_w1, req.phone_w0};
      mail  <= MAIL_W'({req.mail_w3, req.mail_w2, req.mail_w1, req.mail_w0});
    end
  end

  assign full    = (count == CNT_W'(DEPTH));
  assign any_hit = hits[DEPTH];

  assign ctl.cmp_en    = cmp_en;
  assign ctl.shift_all = fire && (cmd == CMD_INSERT) && !full;
  assign ctl.shift_hit = fire && (cmd == CMD_SEARCH) && any_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.shift_all) begin
      count <= count + CNT_W'(1);
    end
  end

  // Cell row
  assign hits[0] = 1'b0;

  always_comb begin
    front_rec.name  = key;
    front_rec.phone = (cmd == CMD_INSERT) ? phone : found_rec.phone;
    front_rec.mail  = (cmd == CMD_INSERT) ? mail  : found_rec.mail;
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    assign live[k]  = (CNT_W'(k) < count);
    assign prevs[k] = (k == 0) ? front_rec : recs[(k == 0) ? 0 : k - 1];

    mtf_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .live    (live[k]),
      .key     (key),
      .prev    (prevs[k]),
      .rec     (recs[k]),
      .hit_in  (hits[k]),
      .hit_out (hits[k+1]),
      .sel     (sel[k]),
      .found   (founds[k])
    );
  end

  // At most one cell selects, so an OR picks its record and index.
  always_comb begin
    found_rec = '0;
    pos       = '0;
    for (int k = 0; k < DEPTH; k++) begin
      found_rec = found_rec | founds[k];
      if (sel[k]) begin
        pos = pos | POS_W'(k);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (cmd == CMD_INSERT) begin
        status      <= full ? STAT_FULL : STAT_INSERTED;
        position    <= '0;
        found_phone <= '0;
        found_mail  <= '0;
      end else if (any_hit) begin
        status      <= STAT_FOUND;
        position    <= pos;
        found_phone <= found_rec.phone;
        found_mail  <= 256'(found_rec.mail);
      end else begin
        status      <= STAT_NOT_FOUND;
        position    <= '0;
        found_phone <= '0;
        found_mail  <= '0;
      end
    end
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.status         = status;
  assign rsp.position       = position;
  assign rsp.found_phone_w0 = found_phone[63:0];
  assign rsp.found_phone_w1 = found_phone[127:64];
  assign rsp.found_phone_w2 = found_phone[159:128];
  assign rsp.found_mail_w0  = found_mail[63:0];
  assign rsp.found_mail_w1  = found_mail[127:64];
  assign rsp.found_mail_w2  = found_mail[191:128];
  assign rsp.found_mail_w3  = found_mail[255:192];

  `CHK_ALWAYS(a_count_bound, clk, rst, count <= CNT_W'(DEPTH))
  `CHK_ALWAYS(a_one_match, clk, rst, $onehot0(sel))
  `CHK_NEXT(a_count_step, clk, rst, ctl.shift_all, count == $past(count) + CNT_W'(1))
  `CHK_SAME(a_rsp_from_upd, clk, rst, $rose(rsp_valid), $past(state) == S_UPD)
  `CHK_SAME(a_shift_excl, clk, rst, ctl.shift_all || ctl.shift_hit, fire && !cmp_en)

endmodule
